// ===== design/tournament_branch_predictor_assert.svh =====
// Assertion macros for the tournament branch predictor checker.
// Depends on nothing; included by the checker file only.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// Antecedent in one cycle implies consequent in the next, masked by reset.
`define TBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, checked during reset too.
`define TBP_ASSERT_NEXT_NR(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same cycle, checked during reset too.
`define TBP_ASSERT_NOW_NR(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/tbp_pkg.sv =====
// Shared types, codes and counter helpers of the tournament branch predictor.
// Depends on nothing; imported by tbp_cmd_if and the predictor modules.
`default_nettype none

package tbp_pkg;

    localparam int unsigned PC_WIDTH = 32;

    // Command codes.
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_TRAIN   = 1'b1;

    typedef logic [1:0] t_ctr;

    // Counter values: 0 strong not taken .. 3 strong taken.
    localparam t_ctr CTR_MIN     = 2'd0;
    localparam t_ctr CTR_WEAK_NT = 2'd1;
    localparam t_ctr CTR_MAX     = 2'd3;

    // Control of one pipeline slot.
    typedef struct packed {
        logic valid;
        logic train;
        logic taken;
    } t_ctl;

    function automatic t_ctr sat_move(input t_ctr c, input logic up);
        t_ctr r;
        if (up) begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end else begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return r;
    endfunction

    function automatic logic ctr_taken(input t_ctr c);
        return c[1];
    endfunction

endpackage

`default_nettype wire

// ===== design/tbp_if.sv =====
// Handshake interfaces of the predictor: command channel in, prediction channel out.
// Depends on tbp_pkg for the address width.
`default_nettype none

interface tbp_cmd_if import tbp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [PC_WIDTH-1:0] pc;
    logic                outcome;

    modport source (output valid, output command, output pc, output outcome, input ready);
    modport sink   (input valid, input command, input pc, input outcome, output ready);
endinterface

interface tbp_pred_if;
    logic valid;
    logic ready;
    logic prediction;

    modport source (output valid, output prediction, input ready);
    modport sink   (input valid, input prediction, output ready);
endinterface

`default_nettype wire

// ===== design/tournament_branch_predictor.sv =====
// Top level of the tournament branch predictor: global history, clearing pass,
// output register; instantiates tbp_hist_stage and tbp_ctr_stage, uses tbp_pkg and tbp_if.
`default_nettype none

// Tournament branch predictor. Each command transaction is either a predict
// (command 0), which returns one prediction transaction, or a train (command 1),
// which returns nothing and updates the local, global and chooser counters and
// both histories with the outcome. One command is accepted every cycle unless
// the clearing pass runs or a finished prediction finds the output register
// stalled; a prediction passes through two dependent memory reads (local
// history table, then counter tables) and then the output register. After
// reset a clearing pass over 2**max(LOCAL_BITS, GLOBAL_BITS) indices (4096 at
// the defaults) writes the reset values into all tables, and no command is
// accepted until it is done. While a prediction waits in the output register,
// later commands keep flowing until another prediction would need that register.
module tournament_branch_predictor import tbp_pkg::*; #(
    parameter int unsigned LOCAL_BITS  = 10,
    parameter int unsigned GLOBAL_BITS = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tbp_cmd_if.sink     i_cmd,
    tbp_pred_if.source  o_pred
);

    localparam int unsigned CLR_BITS = (LOCAL_BITS > GLOBAL_BITS) ? LOCAL_BITS : GLOBAL_BITS;

    logic [GLOBAL_BITS-1:0] r_ghist;
    logic                   r_clr_busy;
    logic [CLR_BITS-1:0]    r_clr_idx;
    logic                   r_out_valid;
    logic                   r_out_pred;

    t_ctl                   s1_ctl;
    logic [LOCAL_BITS-1:0]  s1_lhist;
    logic [GLOBAL_BITS-1:0] s1_gidx;
    t_ctl                   s2_ctl;
    logic                   s2_pred;

    logic n_adv;
    logic n_accept;
    logic n_train;
    logic n_produce;

    assign n_train   = (i_cmd.command == CMD_TRAIN);
    assign n_produce = s2_ctl.valid && !s2_ctl.train;

    // The pipeline moves as one unless a finished prediction has nowhere to go.
    assign n_adv       = !(n_produce && r_out_valid && !o_pred.ready);
    assign i_cmd.ready = n_adv && !r_clr_busy;
    assign n_accept    = i_cmd.valid && i_cmd.ready;

    // The global history depends only on the outcomes, so it is shifted at accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghist <= '0;
        end else if (n_accept && n_train) begin
            r_ghist <= {r_ghist[GLOBAL_BITS-2:0], i_cmd.outcome};
        end
    end

    // The clearing pass writes one entry of every table per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    tbp_hist_stage #(
        .LOCAL_BITS  (LOCAL_BITS),
        .GLOBAL_BITS (GLOBAL_BITS)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (n_adv),
        .i_accept   (n_accept),
        .i_train    (n_train),
        .i_taken    (i_cmd.outcome),
        .i_slot     (i_cmd.pc[LOCAL_BITS-1:0]),
        .i_gidx     (r_ghist),
        .i_clr_busy (r_clr_busy),
        .i_clr_idx  (r_clr_idx[LOCAL_BITS-1:0]),
        .o_ctl      (s1_ctl),
        .o_lhist    (s1_lhist),
        .o_gidx     (s1_gidx)
    );

    tbp_ctr_stage #(
        .LOCAL_BITS  (LOCAL_BITS),
        .GLOBAL_BITS (GLOBAL_BITS),
        .CLR_BITS    (CLR_BITS)
    ) u_ctr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (n_adv),
        .i_ctl        (s1_ctl),
        .i_lhist      (s1_lhist),
        .i_gidx       (s1_gidx),
        .i_clr_busy   (r_clr_busy),
        .i_clr_idx    (r_clr_idx),
        .o_ctl        (s2_ctl),
        .o_prediction (s2_pred)
    );

    // The output register holds a prediction until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_adv && n_produce) begin
            r_out_valid <= 1'b1;
        end else if (o_pred.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv && n_produce) begin
            r_out_pred <= s2_pred;
        end
    end

    assign o_pred.valid      = r_out_valid;
    assign o_pred.prediction = r_out_pred;

endmodule

`default_nettype wire

// ===== design/tbp_hist_stage.sv =====
// First pipeline stage: the local history table and its read with forwarding.
// Depends on tbp_pkg.
`default_nettype none

module tbp_hist_stage import tbp_pkg::*; #(
    parameter int unsigned LOCAL_BITS  = 10,
    parameter int unsigned GLOBAL_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire logic                   i_accept,
    input  wire logic                   i_train,
    input  wire logic                   i_taken,
    input  wire logic [LOCAL_BITS-1:0]  i_slot,
    input  wire logic [GLOBAL_BITS-1:0] i_gidx,
    input  wire logic                   i_clr_busy,
    input  wire logic [LOCAL_BITS-1:0]  i_clr_idx,
    output t_ctl                        o_ctl,
    output logic [LOCAL_BITS-1:0]       o_lhist,
    output logic [GLOBAL_BITS-1:0]      o_gidx
);

    localparam int unsigned LOCAL_SIZE = 1 << LOCAL_BITS;

    logic [LOCAL_BITS-1:0] r_lht [LOCAL_SIZE];

    t_ctl                   r_ctl;
    logic [LOCAL_BITS-1:0]  r_slot;
    logic [GLOBAL_BITS-1:0] r_gidx;
    logic [LOCAL_BITS-1:0]  r_lht_q;
    logic                   r_fwd;
    logic [LOCAL_BITS-1:0]  r_fwd_val;

    logic [LOCAL_BITS-1:0]  n_lhist;
    logic [LOCAL_BITS-1:0]  n_lhist_new;
    logic                   n_write;

    // The table read misses a write made at the same edge, so that value is forwarded.
    assign n_lhist     = r_fwd ? r_fwd_val : r_lht_q;
    assign n_lhist_new = {n_lhist[LOCAL_BITS-2:0], r_ctl.taken};
    assign n_write     = i_adv && r_ctl.valid && r_ctl.train;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_fwd <= 1'b0;
        end else if (i_adv) begin
            r_ctl <= '{valid: i_accept, train: i_train, taken: i_taken};
            r_fwd <= n_write && (r_slot == i_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_slot    <= i_slot;
            r_gidx    <= i_gidx;
            r_fwd_val <= n_lhist_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lht_q <= r_lht[i_slot];
        end
        if (i_clr_busy) begin
            r_lht[i_clr_idx] <= '0;
        end else if (n_write) begin
            r_lht[r_slot] <= n_lhist_new;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_lhist = n_lhist;
    assign o_gidx  = r_gidx;

endmodule

`default_nettype wire

// ===== design/tbp_ctr_stage.sv =====
// Second pipeline stage: local, global and chooser counter tables, prediction and training.
// Depends on tbp_pkg.
`default_nettype none

module tbp_ctr_stage import tbp_pkg::*; #(
    parameter int unsigned LOCAL_BITS  = 10,
    parameter int unsigned GLOBAL_BITS = 12,
    parameter int unsigned CLR_BITS    = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire t_ctl                   i_ctl,
    input  wire logic [LOCAL_BITS-1:0]  i_lhist,
    input  wire logic [GLOBAL_BITS-1:0] i_gidx,
    input  wire logic                   i_clr_busy,
    input  wire logic [CLR_BITS-1:0]    i_clr_idx,
    output t_ctl                        o_ctl,
    output logic                        o_prediction
);

    localparam int unsigned LOCAL_SIZE  = 1 << LOCAL_BITS;
    localparam int unsigned GLOBAL_SIZE = 1 << GLOBAL_BITS;

    t_ctr r_lctr [LOCAL_SIZE];
    t_ctr r_gctr [GLOBAL_SIZE];
    t_ctr r_cctr [GLOBAL_SIZE];

    t_ctl                   r_ctl;
    logic [LOCAL_BITS-1:0]  r_lhist;
    logic [GLOBAL_BITS-1:0] r_gidx;
    t_ctr                   r_l_q;
    t_ctr                   r_g_q;
    t_ctr                   r_c_q;
    logic                   r_lfwd;
    logic                   r_gfwd;
    t_ctr                   r_lfwd_val;
    t_ctr                   r_gfwd_val;
    t_ctr                   r_cfwd_val;

    t_ctr n_l;
    t_ctr n_g;
    t_ctr n_c;
    t_ctr n_l_new;
    t_ctr n_g_new;
    t_ctr n_c_new;
    logic n_lp;
    logic n_gp;
    logic n_write;

    assign n_l = r_lfwd ? r_lfwd_val : r_l_q;
    assign n_g = r_gfwd ? r_gfwd_val : r_g_q;
    assign n_c = r_gfwd ? r_cfwd_val : r_c_q;

    assign n_lp = ctr_taken(n_l);
    assign n_gp = ctr_taken(n_g);

    always_comb begin
        n_l_new = sat_move(n_l, r_ctl.taken);
        n_g_new = sat_move(n_g, r_ctl.taken);
        n_c_new = n_c;
        // The chooser only learns when exactly one side was right.
        if ((n_lp == r_ctl.taken) != (n_gp == r_ctl.taken)) begin
            n_c_new = sat_move(n_c, n_lp == r_ctl.taken);
        end
    end

    assign n_write = i_adv && r_ctl.valid && r_ctl.train;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_lfwd <= 1'b0;
            r_gfwd <= 1'b0;
        end else if (i_adv) begin
            r_ctl  <= i_ctl;
            r_lfwd <= n_write && (r_lhist == i_lhist);
            r_gfwd <= n_write && (r_gidx == i_gidx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lhist    <= i_lhist;
            r_gidx     <= i_gidx;
            r_lfwd_val <= n_l_new;
            r_gfwd_val <= n_g_new;
            r_cfwd_val <= n_c_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_l_q <= r_lctr[i_lhist];
        end
        if (i_clr_busy) begin
            r_lctr[i_clr_idx[LOCAL_BITS-1:0]] <= CTR_WEAK_NT;
        end else if (n_write) begin
            r_lctr[r_lhist] <= n_l_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_g_q <= r_gctr[i_gidx];
        end
        if (i_clr_busy) begin
            r_gctr[i_clr_idx[GLOBAL_BITS-1:0]] <= CTR_WEAK_NT;
        end else if (n_write) begin
            r_gctr[r_gidx] <= n_g_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_q <= r_cctr[i_gidx];
        end
        if (i_clr_busy) begin
            r_cctr[i_clr_idx[GLOBAL_BITS-1:0]] <= CTR_WEAK_NT;
        end else if (n_write) begin
            r_cctr[r_gidx] <= n_c_new;
        end
    end

    assign o_ctl        = r_ctl;
    assign o_prediction = ctr_taken(n_c) ? n_lp : n_gp;

endmodule

`default_nettype wire

// ===== design/tbp_checker.sv =====
// Port-level checks of the tournament branch predictor and the bind that attaches them.
// Depends on tournament_branch_predictor_assert.svh.
`default_nettype none

`include "tournament_branch_predictor_assert.svh"

module tbp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_prediction
);

    // A prediction waiting for the sink stays offered.
    `TBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "prediction dropped while stalled")

    // A stalled prediction keeps its value.
    `TBP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_prediction), "prediction changed while stalled")

    // Reset empties the output register.
    `TBP_ASSERT_NEXT_NR(a_rst_out, i_clk, !i_rst_n, !i_out_valid, "prediction valid after reset")

    // The clearing pass holds off commands right after reset.
    `TBP_ASSERT_NOW_NR(a_clr_block, i_clk, $rose(i_rst_n), !i_in_ready, "command accepted during clearing pass")

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_cmd.ready),
    .i_out_valid      (o_pred.valid),
    .i_out_ready      (o_pred.ready),
    .i_out_prediction (o_pred.prediction)
);

`default_nettype wire
